// ===== rtl/core/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types and constants of the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int unsigned SHORT_WAIT_US = 50;
  localparam int unsigned LONG_WAIT_US  = 2000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WAIT_W     = 26;
  localparam int HOLD_W     = 36;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUS_8BIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_LINES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_FONT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_CYCLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_DELAY_MS = 3'd5;

  // request codes
  localparam logic [3:0] REQ_CHAR    = 4'd0;
  localparam logic [3:0] REQ_CLEAR   = 4'd1;
  localparam logic [3:0] REQ_HOME    = 4'd2;
  localparam logic [3:0] REQ_ADDR    = 4'd3;
  localparam logic [3:0] REQ_DISPLAY = 4'd4;
  localparam logic [3:0] REQ_ENTRY   = 4'd5;
  localparam logic [3:0] REQ_SHIFT_L = 4'd6;
  localparam logic [3:0] REQ_SHIFT_R = 4'd7;
  localparam logic [3:0] REQ_FUNCSET = 4'd8;
  localparam logic [3:0] REQ_INIT    = 4'd9;

  // controller commands
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
  localparam logic [7:0] ADDR_MASK       = 8'h7F;
  localparam logic [7:0] CMD_DISPLAY     = 8'h08;
  localparam logic [7:0] CMD_SHIFT_L     = 8'h18;
  localparam logic [7:0] CMD_SHIFT_R     = 8'h1C;
  localparam logic [7:0] CMD_FUNCSET     = 8'h20;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_RIGHT = 8'h06;

  typedef struct packed {
    logic                  bus_8bit;
    logic                  two_lines;
    logic                  large_font;
    logic [9:0]            cycles_per_us;
    logic [7:0]            pulse_cycles;
    logic [15:0]           char_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0] req_type;
    logic [7:0] char_code;
    logic [7:0] ddram_addr;
    logic       disp_enable;
    logic [1:0] cursor_style;
    logic [1:0] entry_mode;
  } in_item_t;

  typedef struct packed {
    logic              reg_select;
    logic              enable_pin;
    logic [7:0]        bus_value;
    logic [HOLD_W-1:0] hold_cycles;
    logic              last_phase;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              rs;
    logic              init;
    logic [7:0]        byte0;
    logic [WAIT_W-1:0] wait_us;
  } job_t;

endpackage

// ===== rtl/core/lcdseq_front.sv =====
// ----------------------------------------------------------------------------
// lcdseq_front
// Accepts requests, encodes the command or data byte and its settle wait.
// ----------------------------------------------------------------------------
module lcdseq_front (
  input  lcdseq_pkg::in_item_t in_item,
  input  logic                 start,
  input  logic                 full,
  input  lcdseq_pkg::cfg_t     cfg,
  output logic                 push,
  output lcdseq_pkg::job_t     job
);

  logic                          accept;
  logic                          known;
  logic [7:0]                    funcset;
  logic [7:0]                    entry_byte;
  logic [lcdseq_pkg::WAIT_W-1:0] delay_ext;
  logic [lcdseq_pkg::WAIT_W-1:0] char_wait;

  assign accept = start & ~full;
  assign push   = accept & known;

  assign funcset = lcdseq_pkg::CMD_FUNCSET | {3'b000, cfg.bus_8bit, cfg.two_lines,
                   cfg.large_font, 2'b00};

  // ms * 1000 as shifts: 1024 - 16 - 8
  assign delay_ext = lcdseq_pkg::WAIT_W'(cfg.char_delay_ms);
  assign char_wait = lcdseq_pkg::WAIT_W'(lcdseq_pkg::SHORT_WAIT_US)
                   + (delay_ext << 10) - (delay_ext << 4) - (delay_ext << 3);

  always_comb begin
    case (in_item.entry_mode)
      2'd0:    entry_byte = 8'h06;
      2'd1:    entry_byte = 8'h04;
      2'd2:    entry_byte = 8'h05;
      default: entry_byte = 8'h07;
    endcase
  end

  always_comb begin
    known       = 1'b1;
    job.rs      = 1'b0;
    job.init    = 1'b0;
    job.byte0   = 8'h00;
    job.wait_us = lcdseq_pkg::WAIT_W'(lcdseq_pkg::SHORT_WAIT_US);
    case (in_item.req_type)
      lcdseq_pkg::REQ_CHAR: begin
        job.rs      = 1'b1;
        job.byte0   = in_item.char_code;
        job.wait_us = char_wait;
      end
      lcdseq_pkg::REQ_CLEAR: begin
        job.byte0   = lcdseq_pkg::CMD_CLEAR;
        job.wait_us = lcdseq_pkg::WAIT_W'(lcdseq_pkg::LONG_WAIT_US);
      end
      lcdseq_pkg::REQ_HOME: begin
        job.byte0   = lcdseq_pkg::CMD_HOME;
        job.wait_us = lcdseq_pkg::WAIT_W'(lcdseq_pkg::LONG_WAIT_US);
      end
      lcdseq_pkg::REQ_ADDR: begin
        job.byte0 = lcdseq_pkg::CMD_SET_ADDR | (in_item.ddram_addr & lcdseq_pkg::ADDR_MASK);
      end
      lcdseq_pkg::REQ_DISPLAY: begin
        job.byte0 = lcdseq_pkg::CMD_DISPLAY | {5'b00000, in_item.disp_enable,
                    in_item.cursor_style[0], in_item.cursor_style[1]};
      end
      lcdseq_pkg::REQ_ENTRY:   job.byte0 = entry_byte;
      lcdseq_pkg::REQ_SHIFT_L: job.byte0 = lcdseq_pkg::CMD_SHIFT_L;
      lcdseq_pkg::REQ_SHIFT_R: job.byte0 = lcdseq_pkg::CMD_SHIFT_R;
      lcdseq_pkg::REQ_FUNCSET: job.byte0 = funcset;
      lcdseq_pkg::REQ_INIT: begin
        job.init  = 1'b1;
        job.byte0 = funcset;
      end
      // drop unknown requests
      default: known = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/lcdseq_fifo.sv =====
// ----------------------------------------------------------------------------
// lcdseq_fifo
// Two-entry job queue between the front decoder and the phase sequencer.
// ----------------------------------------------------------------------------
module lcdseq_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcdseq_pkg::job_t push_job,
  input  logic             pop,
  output lcdseq_pkg::job_t pop_job,
  output logic             empty,
  output logic             full
);

  lcdseq_pkg::job_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job queue underflow");
`endif

endmodule

// ===== rtl/core/lcdseq_back.sv =====
// ----------------------------------------------------------------------------
// lcdseq_back
// Phase sequencer: walks the bytes of a job and emits one pin phase a cycle.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcdseq_pkg::cfg_t      cfg,
  input  logic                  fifo_empty,
  input  lcdseq_pkg::job_t      fifo_job,
  output logic                  pop,
  output logic                  out_valid,
  output lcdseq_pkg::out_item_t out_item
);

  lcdseq_pkg::job_t      job_r;
  logic                  active_r;
  logic [2:0]            ph_r;
  logic [1:0]            byte_idx_r;
  logic                  out_valid_r;
  lcdseq_pkg::out_item_t out_r;

  logic [7:0]                    cur_byte;
  logic                          last_byte;
  logic [lcdseq_pkg::WAIT_W-1:0] cur_wait;
  logic [2:0]                    settle_ph;
  logic                          settle;
  logic [9:0]                    cpu;
  logic [7:0]                    pulse;
  logic                          done_job;
  lcdseq_pkg::out_item_t         phase;

  always_comb begin
    cur_byte = job_r.byte0;
    if (job_r.init) begin
      case (byte_idx_r)
        2'd0:    cur_byte = job_r.byte0;
        2'd1:    cur_byte = lcdseq_pkg::CMD_DISPLAY_ON;
        2'd2:    cur_byte = lcdseq_pkg::CMD_ENTRY_RIGHT;
        default: cur_byte = lcdseq_pkg::CMD_CLEAR;
      endcase
    end
  end

  assign last_byte = ~job_r.init | (byte_idx_r == 2'd3);
  assign cur_wait  = (job_r.init && last_byte) ?
                     lcdseq_pkg::WAIT_W'(lcdseq_pkg::LONG_WAIT_US) : job_r.wait_us;

  assign settle_ph = cfg.bus_8bit ? 3'd2 : 3'd4;
  assign settle    = (ph_r == settle_ph);
  assign cpu       = (cfg.cycles_per_us == 10'd0) ? 10'd1 : cfg.cycles_per_us;
  assign pulse     = (cfg.pulse_cycles == 8'd0) ? 8'd1 : cfg.pulse_cycles;
  assign done_job  = active_r & settle & last_byte;
  assign pop       = ~fifo_empty & (~active_r | done_job);

  always_comb begin
    phase.reg_select = job_r.rs;
    // strobe pairs go low then high; the settle phase is even and low
    phase.enable_pin = ph_r[0];
    if (cfg.bus_8bit) begin
      phase.bus_value = cur_byte;
    end else if (ph_r < 3'd2) begin
      phase.bus_value = {cur_byte[7:4], 4'h0};
    end else begin
      phase.bus_value = {cur_byte[3:0], 4'h0};
    end
    if (settle) begin
      phase.hold_cycles = lcdseq_pkg::HOLD_W'(cpu) * lcdseq_pkg::HOLD_W'(cur_wait);
    end else begin
      phase.hold_cycles = lcdseq_pkg::HOLD_W'(pulse);
    end
    phase.last_phase = settle & last_byte;
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      out_r <= phase;
    end
    if (pop) begin
      job_r <= fifo_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      ph_r        <= 3'd0;
      byte_idx_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      if (pop) begin
        active_r   <= 1'b1;
        ph_r       <= 3'd0;
        byte_idx_r <= 2'd0;
      end else if (done_job) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        if (settle) begin
          // advance to the next byte of an init sequence
          ph_r       <= 3'd0;
          byte_idx_r <= byte_idx_r + 2'd1;
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_strobe_followed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.enable_pin |=> out_valid_r)
    else $error("enable high phase not followed by another phase");
  a_last_is_settle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_phase |-> !out_r.enable_pin && out_r.hold_cycles != '0)
    else $error("final phase is not a settle phase");
`endif

endmodule

// ===== rtl/core/char_lcd_bus_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_core
// Turns character LCD requests into a stream of pin phases.
// ----------------------------------------------------------------------------
// One request expands to 3 phases per byte on an 8-bit bus or 5 per byte in
// 4-bit mode; init sends four bytes, so a request yields 3 to 20 phases. The
// back sequencer emits one phase per clock on out_item with out_valid high for
// that single cycle, and the receiver cannot hold it off: it must capture each
// phase and play out hold_cycles itself. A request is taken when start is high
// and busy is low; busy rises only when the two-entry job queue in front of the
// sequencer is full, so back-to-back requests are taken while earlier ones are
// still emitting. Sustained request rate is set by the sequencer and the phase
// count of each request. Unknown request codes are taken and produce no phases.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  lcdseq_pkg::in_item_t                in_item,
  output logic                                out_valid,
  output lcdseq_pkg::out_item_t               out_item,
  input  logic                                cfg_we,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcdseq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lcdseq_pkg::cfg_t cfg_r;
  lcdseq_pkg::job_t push_job;
  lcdseq_pkg::job_t pop_job;
  logic             push;
  logic             pop;
  logic             fifo_empty;
  logic             fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_8bit      <= 1'b0;
      cfg_r.two_lines     <= 1'b1;
      cfg_r.large_font    <= 1'b0;
      cfg_r.cycles_per_us <= 10'd16;
      cfg_r.pulse_cycles  <= 8'd3;
      cfg_r.char_delay_ms <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdseq_pkg::REG_BUS_8BIT:      cfg_r.bus_8bit      <= cfg_data[0];
        lcdseq_pkg::REG_TWO_LINES:     cfg_r.two_lines     <= cfg_data[0];
        lcdseq_pkg::REG_LARGE_FONT:    cfg_r.large_font    <= cfg_data[0];
        lcdseq_pkg::REG_CYCLES_PER_US: cfg_r.cycles_per_us <= cfg_data[9:0];
        lcdseq_pkg::REG_PULSE_CYCLES:  cfg_r.pulse_cycles  <= cfg_data[7:0];
        lcdseq_pkg::REG_CHAR_DELAY_MS: cfg_r.char_delay_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = fifo_full;

  lcdseq_front u_front (
    .in_item (in_item),
    .start   (start),
    .full    (fifo_full),
    .cfg     (cfg_r),
    .push    (push),
    .job     (push_job)
  );

  lcdseq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  lcdseq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .fifo_job   (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
